/* hdl/gfcs_pkg.sv */
// Shared types and constants for the gradient fan colour shader.
// Used by the channel interfaces and by the gfcs_* modules apart from gfcs_ram; no dependencies.
package gfcs_pkg;

  // field widths
  localparam int CMD_W    = 2;
  localparam int SLOT_W   = 3;
  localparam int OFF_W    = 17;
  localparam int COL_W    = 24;
  localparam int PROJ_W   = 20;
  localparam int MEAN_W   = 20;
  localparam int CHAN_W   = 8;
  localparam int WALK_W   = 4;
  localparam int ENTRY_W  = OFF_W + COL_W;

  // configuration port
  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 3;
  localparam logic REG_STOPS_IDX = 1'b0;   // paddr[2] of stops_in_use

  localparam int MAX_STOPS_DEF = 8;
  localparam logic [WALK_W-1:0] MIN_STOPS   = 4'd2;
  localparam logic [WALK_W-1:0] STOPS_RESET = 4'd2;

  // decoupling queue
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;
  localparam int QCNT_W      = 3;

  // commands
  localparam logic [CMD_W-1:0] CMD_START = 2'd0;
  localparam logic [CMD_W-1:0] CMD_WRITE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_SHADE = 2'd2;
  localparam logic [CMD_W-1:0] CMD_NONE  = 2'd3;

  // Q16 arithmetic
  localparam logic [OFF_W-1:0] Q16_ONE = 17'h10000;
  // floor(sum/3) = ((sum + 3*2^21) * ceil(2^25/3)) >> 25  - 2^21
  localparam int SUM_W  = PROJ_W + 2;
  localparam int BIAS_W = SUM_W + 1;
  localparam logic [BIAS_W-1:0] MEAN_BIAS   = 23'd6291456;
  localparam logic [23:0]       RECIP3      = 24'hAAAAAB;
  localparam int                RECIP_SHIFT = 25;
  localparam logic [SUM_W-1:0]  MEAN_UNBIAS = 22'd2097152;

  localparam int FRAC_W = 16;

  typedef struct packed {
    logic [CMD_W-1:0]         kind;
    logic [SLOT_W-1:0]        slot;
    logic [OFF_W-1:0]         offset;
    logic [COL_W-1:0]         color;
    logic signed [MEAN_W-1:0] mean;
  } item_t;

endpackage

/* hdl/gfcs_in_if.sv */
// Input channel of the shader: valid/ready handshake plus one command item.
// Depends on gfcs_pkg for field widths.
interface gfcs_in_if;
  logic                               valid;
  logic                               ready;
  logic [gfcs_pkg::CMD_W-1:0]         cmd;
  logic [gfcs_pkg::SLOT_W-1:0]        slot;
  logic [gfcs_pkg::OFF_W-1:0]         slot_offset;
  logic [gfcs_pkg::COL_W-1:0]         slot_color;
  logic signed [gfcs_pkg::PROJ_W-1:0] proj_apex;
  logic signed [gfcs_pkg::PROJ_W-1:0] proj_left;
  logic signed [gfcs_pkg::PROJ_W-1:0] proj_right;

  modport source (output valid, cmd, slot, slot_offset, slot_color,
                  proj_apex, proj_left, proj_right, input ready);
  modport sink   (input valid, cmd, slot, slot_offset, slot_color,
                  proj_apex, proj_left, proj_right, output ready);
endinterface

/* hdl/gfcs_out_if.sv */
// Result channel of the shader: valid/ready handshake plus one fill colour.
// Depends on gfcs_pkg for field widths.
interface gfcs_out_if;
  logic                         valid;
  logic                         ready;
  logic [gfcs_pkg::CHAN_W-1:0]  fill_red;
  logic [gfcs_pkg::CHAN_W-1:0]  fill_green;
  logic [gfcs_pkg::CHAN_W-1:0]  fill_blue;
  logic [gfcs_pkg::WALK_W-1:0]  segment_index;

  modport source (output valid, fill_red, fill_green, fill_blue, segment_index,
                  input ready);
  modport sink   (input valid, fill_red, fill_green, fill_blue, segment_index,
                  output ready);
endinterface

/* hdl/gradient_fan_color_shader_core.sv */
// Top level of the gradient fan colour shader: APB stop-count register,
// front end, decoupling queue and walk/blend engine.
// Depends on gfcs_pkg, gfcs_in_if, gfcs_out_if, gfcs_front, gfcs_queue, gfcs_back.
//
//  channel   dir  handshake            payload
//  in_ch     in   valid/ready          cmd, slot, slot_offset, slot_color, proj_*
//  out_ch    out  valid/ready          fill_red/green/blue, segment_index
//  cfg_*     in   APB psel/penable     stops_in_use at byte address 0
//
// The front end takes one item a cycle until the four-entry queue fills and
// forms the mean from a registered biased sum and reciprocal product. The
// engine does a stop write when idle and a start by reloading stop 0. A shade
// walks the stops (check, load), then blends between two stops, using the
// serial divider unless the fraction clamps, or fetches a fixed colour before
// the first stop or past the end. Reset is synchronous, active low, and clears
// the walk state; the stop table is undefined until written. A stalled result
// holds the engine in its final step while the front end still fills the queue.
module gradient_fan_color_shader_core #(
  parameter int MAX_STOPS = gfcs_pkg::MAX_STOPS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  gfcs_in_if.sink                           in_ch,
  gfcs_out_if.source                        out_ch,
  input  logic                              cfg_psel,
  input  logic                              cfg_penable,
  input  logic                              cfg_pwrite,
  input  logic [gfcs_pkg::CFG_ADDR_W-1:0]   cfg_paddr,
  input  logic [gfcs_pkg::CFG_DATA_W-1:0]   cfg_pwdata,
  output logic [gfcs_pkg::CFG_DATA_W-1:0]   cfg_prdata,
  output logic                              cfg_pready
);

  logic [gfcs_pkg::WALK_W-1:0] stops_r;
  logic [gfcs_pkg::WALK_W-1:0] count;
  logic                        reg_hit;

  logic            push_valid, push_ready, pop_valid, pop_ready;
  gfcs_pkg::item_t push_item, pop_item;

  // byte lanes below bit 2 are ignored
  assign reg_hit    = (cfg_paddr[2] == gfcs_pkg::REG_STOPS_IDX);
  assign cfg_pready = 1'b1;
  assign cfg_prdata = reg_hit ? gfcs_pkg::CFG_DATA_W'(stops_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stops_r <= gfcs_pkg::STOPS_RESET;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && reg_hit) begin
      stops_r <= cfg_pwdata[gfcs_pkg::WALK_W-1:0];
    end
  end

  // active stop count, clamped to 2..MAX_STOPS
  always_comb begin
    count = stops_r;
    if (stops_r < gfcs_pkg::MIN_STOPS) begin
      count = gfcs_pkg::MIN_STOPS;
    end else if (32'(stops_r) > MAX_STOPS) begin
      count = gfcs_pkg::WALK_W'(MAX_STOPS);
    end
  end

  gfcs_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .push_valid (push_valid),
    .push_item  (push_item),
    .push_ready (push_ready)
  );

  gfcs_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_item  (push_item),
    .push_ready (push_ready),
    .pop_valid  (pop_valid),
    .pop_item   (pop_item),
    .pop_ready  (pop_ready)
  );

  gfcs_back #(
    .MAX_STOPS (MAX_STOPS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .count     (count),
    .pop_valid (pop_valid),
    .pop_item  (pop_item),
    .pop_ready (pop_ready),
    .out_ch    (out_ch)
  );

endmodule

/* hdl/gfcs_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module gfcs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* hdl/gfcs_front.sv */
// Front end: takes items, drops unused commands, saturates stop offsets and
// works out the floored mean of the three projections in two stages.
// Depends on gfcs_pkg and gfcs_in_if.
module gfcs_front (
  input  logic           clk,
  input  logic           rst_n,
  gfcs_in_if.sink        in_ch,
  output logic           push_valid,
  output gfcs_pkg::item_t push_item,
  input  logic           push_ready
);

  logic                             s1_v_r, s1_v_nxt;
  gfcs_pkg::item_t                  s1_item_r;
  logic [gfcs_pkg::BIAS_W-1:0]      s1_u_r;
  logic                             s2_v_r, s2_v_nxt;
  gfcs_pkg::item_t                  s2_item_r;
  logic [gfcs_pkg::SUM_W-1:0]       s2_q_r;

  logic                             s1_go;
  logic                             in_take;
  logic signed [gfcs_pkg::SUM_W-1:0] sum;
  logic [gfcs_pkg::BIAS_W-1:0]      u_nxt;
  logic [gfcs_pkg::OFF_W-1:0]       off_sat;
  logic [gfcs_pkg::BIAS_W+24-1:0]   prod;
  gfcs_pkg::item_t                  s1_item_nxt;

  assign s1_go       = s1_v_r && (!s2_v_r || push_ready);
  assign in_ch.ready = !s1_v_r || s1_go;
  assign in_take     = in_ch.valid && in_ch.ready;

  always_comb begin
    sum = gfcs_pkg::SUM_W'(in_ch.proj_apex) + gfcs_pkg::SUM_W'(in_ch.proj_left)
        + gfcs_pkg::SUM_W'(in_ch.proj_right);
    // bias makes the sum non-negative so the reciprocal multiply floors it
    u_nxt   = {sum[gfcs_pkg::SUM_W-1], sum} + gfcs_pkg::MEAN_BIAS;
    off_sat = (in_ch.slot_offset > gfcs_pkg::Q16_ONE) ? gfcs_pkg::Q16_ONE
                                                       : in_ch.slot_offset;
    s1_item_nxt        = '0;
    s1_item_nxt.kind   = in_ch.cmd;
    s1_item_nxt.slot   = in_ch.slot;
    s1_item_nxt.offset = off_sat;
    s1_item_nxt.color  = in_ch.slot_color;
    prod = s1_u_r * gfcs_pkg::RECIP3;
  end

  always_comb begin
    s1_v_nxt = s1_v_r;
    if (in_take) begin
      s1_v_nxt = (in_ch.cmd != gfcs_pkg::CMD_NONE);
    end else if (s1_go) begin
      s1_v_nxt = 1'b0;
    end
    s2_v_nxt = s2_v_r;
    if (s1_go) begin
      s2_v_nxt = 1'b1;
    end else if (push_ready) begin
      s2_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else begin
      s1_v_r <= s1_v_nxt;
      s2_v_r <= s2_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_item_r <= s1_item_nxt;
      s1_u_r    <= u_nxt;
    end
    if (s1_go) begin
      s2_item_r <= s1_item_r;
      s2_q_r    <= prod[gfcs_pkg::RECIP_SHIFT +: gfcs_pkg::SUM_W];
    end
  end

  always_comb begin
    push_item      = s2_item_r;
    push_item.mean = gfcs_pkg::MEAN_W'(s2_q_r - gfcs_pkg::MEAN_UNBIAS);
  end
  assign push_valid = s2_v_r;

endmodule

/* hdl/gfcs_queue.sv */
// Short FIFO between the front end and the walk/blend engine.
// Depends on gfcs_pkg.
module gfcs_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push_valid,
  input  gfcs_pkg::item_t push_item,
  output logic            push_ready,
  output logic            pop_valid,
  output gfcs_pkg::item_t pop_item,
  input  logic            pop_ready
);

  gfcs_pkg::item_t               store_r [gfcs_pkg::QUEUE_DEPTH];
  logic [gfcs_pkg::QPTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [gfcs_pkg::QCNT_W-1:0]   cnt_r, cnt_nxt;
  logic                          push, pop;

  assign push_ready = (cnt_r != gfcs_pkg::QCNT_W'(gfcs_pkg::QUEUE_DEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_item   = store_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      store_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

/* hdl/gfcs_back.sv */
// Walk/blend engine: owns the stop table RAM, walks the stops, runs the
// serial Q16 divider and the per-channel blend, and holds the result register.
// Depends on gfcs_pkg, gfcs_ram and gfcs_out_if.
module gfcs_back #(
  parameter int MAX_STOPS = gfcs_pkg::MAX_STOPS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [gfcs_pkg::WALK_W-1:0] count,
  input  logic                        pop_valid,
  input  gfcs_pkg::item_t             pop_item,
  output logic                        pop_ready,
  gfcs_out_if.source                  out_ch
);

  localparam int AW = $clog2(MAX_STOPS);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_START  = 4'd1;
  localparam logic [3:0] S_CHECK  = 4'd2;
  localparam logic [3:0] S_LOAD   = 4'd3;
  localparam logic [3:0] S_DECIDE = 4'd4;
  localparam logic [3:0] S_FETCH  = 4'd5;
  localparam logic [3:0] S_DIV    = 4'd6;
  localparam logic [3:0] S_BLEND  = 4'd7;
  localparam logic [3:0] S_OUT    = 4'd8;

  localparam logic [1:0] CH_RED   = 2'd0;
  localparam logic [1:0] CH_GREEN = 2'd1;
  localparam logic [1:0] CH_BLUE  = 2'd2;

  localparam int OW = gfcs_pkg::OFF_W;
  localparam int CW = gfcs_pkg::COL_W;
  localparam int NW = gfcs_pkg::MEAN_W + 1;

  logic [3:0]                   state_r, state_nxt;
  logic [gfcs_pkg::WALK_W-1:0]  walk_r, walk_nxt, cnt_r, cnt_nxt, walk_inc;
  logic [OW-1:0]                lo_off_r, lo_off_nxt, up_off_r, up_off_nxt;
  logic [CW-1:0]                lo_col_r, lo_col_nxt, up_col_r, up_col_nxt;
  logic signed [gfcs_pkg::MEAN_W-1:0] mean_r, mean_nxt;
  logic [OW:0]                  rem_r, rem_nxt;
  logic [OW-1:0]                den_r, den_nxt;
  logic [gfcs_pkg::FRAC_W-1:0]  quo_r, quo_nxt;
  logic [OW-1:0]                s_r, s_nxt;
  logic [3:0]                   step_r, step_nxt;
  logic [1:0]                   chan_r, chan_nxt;
  logic [CW-1:0]                res_col_r, res_col_nxt;
  logic                         out_valid_r, out_valid_nxt;
  logic [gfcs_pkg::CHAN_W-1:0]  out_red_r, out_green_r, out_blue_r;
  logic [gfcs_pkg::WALK_W-1:0]  out_seg_r;

  logic                         ram_we;
  logic [AW-1:0]                rd_addr;
  logic [gfcs_pkg::ENTRY_W-1:0] rdata;
  logic [OW-1:0]                rd_off;
  logic [CW-1:0]                rd_col;
  logic                         slot_ok;
  logic                         res_load;

  logic signed [NW-1:0]         mean_s, up_s, num, den;
  logic [OW:0]                  r2;
  logic                         qbit;
  logic [gfcs_pkg::CHAN_W-1:0]  c0, c1;
  logic signed [8:0]            diff;
  logic signed [26:0]           prod, blend;

  gfcs_ram #(
    .WIDTH (gfcs_pkg::ENTRY_W),
    .DEPTH (MAX_STOPS)
  ) u_stop_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (AW'(32'(pop_item.slot))),
    .wdata ({pop_item.offset, pop_item.color}),
    .raddr (rd_addr),
    .rdata (rdata)
  );

  assign rd_off  = rdata[CW +: OW];
  assign rd_col  = rdata[CW-1:0];
  assign slot_ok = (32'(pop_item.slot) < MAX_STOPS);

  always_comb begin
    mean_s = NW'(mean_r);
    up_s   = $signed(NW'(up_off_r));
    num    = mean_s - $signed(NW'(lo_off_r));
    den    = up_s - $signed(NW'(lo_off_r));
    r2     = {rem_r[OW-1:0], 1'b0};
    qbit   = (r2 >= {1'b0, den_r});
    case (chan_r)
      CH_RED: begin
        c0 = lo_col_r[23:16];
        c1 = up_col_r[23:16];
      end
      CH_GREEN: begin
        c0 = lo_col_r[15:8];
        c1 = up_col_r[15:8];
      end
      default: begin
        c0 = lo_col_r[7:0];
        c1 = up_col_r[7:0];
      end
    endcase
    diff  = $signed({1'b0, c1}) - $signed({1'b0, c0});
    prod  = diff * $signed({1'b0, s_r});
    // c0 + floor((c1-c0)*s / 2^16)
    blend = $signed(27'(c0)) + (prod >>> gfcs_pkg::FRAC_W);
  end

  always_comb begin
    state_nxt   = state_r;
    walk_nxt    = walk_r;
    cnt_nxt     = cnt_r;
    lo_off_nxt  = lo_off_r;
    up_off_nxt  = up_off_r;
    lo_col_nxt  = lo_col_r;
    up_col_nxt  = up_col_r;
    mean_nxt    = mean_r;
    rem_nxt     = rem_r;
    den_nxt     = den_r;
    quo_nxt     = quo_r;
    s_nxt       = s_r;
    step_nxt    = step_r;
    chan_nxt    = chan_r;
    res_col_nxt = res_col_r;
    pop_ready   = 1'b0;
    ram_we      = 1'b0;
    rd_addr     = '0;
    res_load    = 1'b0;
    walk_inc    = walk_r + 1'b1;

    case (state_r)
      S_IDLE: begin
        if (pop_valid) begin
          pop_ready = 1'b1;
          case (pop_item.kind)
            gfcs_pkg::CMD_START: begin
              state_nxt = S_START;
            end
            gfcs_pkg::CMD_WRITE: begin
              ram_we = slot_ok;
            end
            gfcs_pkg::CMD_SHADE: begin
              mean_nxt  = pop_item.mean;
              cnt_nxt   = count;
              walk_nxt  = (walk_r > count) ? count : walk_r;
              state_nxt = S_CHECK;
            end
            default: ;
          endcase
        end
      end
      S_START: begin
        walk_nxt   = '0;
        lo_off_nxt = '0;
        up_off_nxt = rd_off;
        lo_col_nxt = rd_col;
        up_col_nxt = rd_col;
        state_nxt  = S_IDLE;
      end
      S_CHECK: begin
        if (walk_r < cnt_r && up_s < mean_s) begin
          walk_nxt = walk_inc;
          if (walk_inc >= cnt_r) begin
            state_nxt = S_DECIDE;
          end else begin
            lo_off_nxt = up_off_r;
            lo_col_nxt = up_col_r;
            rd_addr    = AW'(32'(walk_inc));
            state_nxt  = S_LOAD;
          end
        end else begin
          state_nxt = S_DECIDE;
        end
      end
      S_LOAD: begin
        up_off_nxt = rd_off;
        up_col_nxt = rd_col;
        state_nxt  = S_CHECK;
      end
      S_DECIDE: begin
        chan_nxt = CH_RED;
        if (walk_r == '0) begin
          state_nxt = S_FETCH;
        end else if (walk_r >= cnt_r) begin
          rd_addr   = AW'(32'(cnt_r - 1'b1));
          state_nxt = S_FETCH;
        end else if (num <= 0) begin
          s_nxt     = '0;
          state_nxt = S_BLEND;
        end else if (num >= den) begin
          // also covers equal and descending offsets
          s_nxt     = gfcs_pkg::Q16_ONE;
          state_nxt = S_BLEND;
        end else begin
          rem_nxt   = num[OW:0];
          den_nxt   = den[OW-1:0];
          quo_nxt   = '0;
          step_nxt  = '0;
          state_nxt = S_DIV;
        end
      end
      S_FETCH: begin
        res_col_nxt = rd_col;
        state_nxt   = S_OUT;
      end
      S_DIV: begin
        rem_nxt  = qbit ? (r2 - {1'b0, den_r}) : r2;
        quo_nxt  = {quo_r[gfcs_pkg::FRAC_W-2:0], qbit};
        step_nxt = step_r + 1'b1;
        if (step_r == 4'(gfcs_pkg::FRAC_W - 1)) begin
          s_nxt     = {1'b0, quo_nxt};
          state_nxt = S_BLEND;
        end
      end
      S_BLEND: begin
        chan_nxt = chan_r + 1'b1;
        case (chan_r)
          CH_RED:   res_col_nxt[23:16] = blend[7:0];
          CH_GREEN: res_col_nxt[15:8]  = blend[7:0];
          default:  res_col_nxt[7:0]   = blend[7:0];
        endcase
        if (chan_r == CH_BLUE) begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_valid_r || out_ch.ready) begin
          res_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    out_valid_nxt = out_valid_r;
    if (res_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      walk_r      <= '0;
      lo_off_r    <= '0;
      up_off_r    <= '0;
      lo_col_r    <= '0;
      up_col_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      walk_r      <= walk_nxt;
      lo_off_r    <= lo_off_nxt;
      up_off_r    <= up_off_nxt;
      lo_col_r    <= lo_col_nxt;
      up_col_r    <= up_col_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r     <= cnt_nxt;
    mean_r    <= mean_nxt;
    rem_r     <= rem_nxt;
    den_r     <= den_nxt;
    quo_r     <= quo_nxt;
    s_r       <= s_nxt;
    step_r    <= step_nxt;
    chan_r    <= chan_nxt;
    res_col_r <= res_col_nxt;
    if (res_load) begin
      out_red_r   <= res_col_r[23:16];
      out_green_r <= res_col_r[15:8];
      out_blue_r  <= res_col_r[7:0];
      out_seg_r   <= walk_r;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.fill_red      = out_red_r;
  assign out_ch.fill_green    = out_green_r;
  assign out_ch.fill_blue     = out_blue_r;
  assign out_ch.segment_index = out_seg_r;

`ifndef ASSERT_OFF
  a_pop_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (pop_valid && pop_ready) |-> (state_r == S_IDLE))
    else $error("item taken from queue while engine busy");

  a_seg_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    res_load |-> (walk_r <= cnt_r))
    else $error("segment index beyond stop count");

  a_load_after_check: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_LOAD) |-> ($past(state_r) == S_CHECK))
    else $error("stop load without walk step");

  a_result_once: assert property (@(posedge clk) disable iff (!rst_n)
    res_load |=> (state_r == S_IDLE))
    else $error("result register loaded outside final step");
`endif

endmodule

/* dv/tb_gradient_fan_color_shader_core.sv */
`timescale 1ns / 100ps
// Self-checking testbench for gradient_fan_color_shader_core: queue-fed driver, checking
// monitor and an in-bench model of the stop walk and colour blend.
// Depends on gfcs_pkg, gfcs_in_if, gfcs_out_if and the shader RTL.
module tb_gradient_fan_color_shader_core;

  localparam int STOP_SLOTS    = gfcs_pkg::MAX_STOPS_DEF;
  localparam int Q16_UNIT      = gfcs_pkg::Q16_ONE;
  localparam int PHASES        = 8;
  localparam int PHASE_ITEMS   = 75;
  localparam int SETTLE_CYCLES = 48;
  localparam int HOLD_CYCLES   = 400;
  localparam int STALL_LIMIT   = 3000;
  localparam logic [gfcs_pkg::CFG_ADDR_W-1:0] STOPS_ADDR = '0;

  typedef struct packed {
    logic [gfcs_pkg::CMD_W-1:0]         cmd;
    logic [gfcs_pkg::SLOT_W-1:0]        slot;
    logic [gfcs_pkg::OFF_W-1:0]         slot_offset;
    logic [gfcs_pkg::COL_W-1:0]         slot_color;
    logic signed [gfcs_pkg::PROJ_W-1:0] proj_apex;
    logic signed [gfcs_pkg::PROJ_W-1:0] proj_left;
    logic signed [gfcs_pkg::PROJ_W-1:0] proj_right;
  } shade_item_t;

  typedef struct packed {
    logic [gfcs_pkg::CHAN_W-1:0] red;
    logic [gfcs_pkg::CHAN_W-1:0] green;
    logic [gfcs_pkg::CHAN_W-1:0] blue;
    logic [gfcs_pkg::WALK_W-1:0] seg;
  } fill_t;

  logic clk;
  logic rst_n;
  logic cfg_psel;
  logic cfg_penable;
  logic cfg_pwrite;
  logic [gfcs_pkg::CFG_ADDR_W-1:0] cfg_paddr;
  logic [gfcs_pkg::CFG_DATA_W-1:0] cfg_pwdata;
  logic [gfcs_pkg::CFG_DATA_W-1:0] cfg_prdata;
  logic cfg_pready;

  gfcs_in_if  in_ch ();
  gfcs_out_if out_ch ();

  gradient_fan_color_shader_core i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // shader model state
  int          stop_off [STOP_SLOTS];
  logic [23:0] stop_col [STOP_SLOTS];
  int          walk_pos = 0;
  int          lo_off = 0;
  int          hi_off = 0;
  logic [23:0] lo_col = '0;
  logic [23:0] hi_col = '0;
  logic [3:0]  stops_cfg = gfcs_pkg::STOPS_RESET;

  shade_item_t cmds_pending [$];
  fill_t       fills_due [$];

  int errors = 0;
  int in_gap_pct = 0;
  int out_stall_pct = 0;
  bit hold_req = 1'b0;
  int gap_left = 0;
  int stall_left = 0;
  int hold_left = 0;
  int quiet_cycles = 0;

  task automatic flag_mismatch(input string msg);
    errors++;
    $display("mismatch at %0t: %s", $realtime, msg);
  endtask

  function automatic logic [7:0] mix_channel(input logic [7:0] c0, input logic [7:0] c1,
                                             input int s);
    longint acc;
    acc = longint'(c0) * longint'(Q16_UNIT - s) + longint'(c1) * longint'(s);
    return 8'(acc >> 16);
  endfunction

  // Advances the model by one item; returns 1 when the item yields a fill colour.
  function automatic bit fill_for_item(input shade_item_t it, output fill_t res);
    int cnt;
    int total;
    int mean;
    int s;
    longint num;
    longint den;
    logic [23:0] c;
    res = '0;
    if (it.cmd == gfcs_pkg::CMD_START) begin
      walk_pos = 0;
      lo_off   = 0;
      hi_off   = stop_off[0];
      lo_col   = stop_col[0];
      hi_col   = stop_col[0];
      return 1'b0;
    end
    if (it.cmd == gfcs_pkg::CMD_WRITE) begin
      stop_off[it.slot] = (it.slot_offset > gfcs_pkg::Q16_ONE) ? Q16_UNIT
                                                                 : int'(it.slot_offset);
      stop_col[it.slot] = it.slot_color;
      return 1'b0;
    end
    if (it.cmd != gfcs_pkg::CMD_SHADE) return 1'b0;

    cnt = int'(stops_cfg);
    if (cnt < 2) cnt = 2;
    if (cnt > STOP_SLOTS) cnt = STOP_SLOTS;
    total = int'($signed(it.proj_apex)) + int'($signed(it.proj_left))
          + int'($signed(it.proj_right));
    // mean rounds towards minus infinity
    mean = (total >= 0) ? total / 3 : -((2 - total) / 3);

    if (walk_pos > cnt) walk_pos = cnt;
    while (walk_pos < cnt && hi_off < mean) begin
      walk_pos++;
      if (walk_pos >= cnt) break;
      lo_col = hi_col;
      hi_col = stop_col[walk_pos];
      lo_off = hi_off;
      hi_off = stop_off[walk_pos];
    end

    if (walk_pos == 0) begin
      c = stop_col[0];
    end else if (walk_pos >= cnt) begin
      c = stop_col[cnt-1];
    end else begin
      num = longint'(mean) - longint'(lo_off);
      den = longint'(hi_off) - longint'(lo_off);
      if (num <= 0) s = 0;
      else if (num >= den) s = Q16_UNIT;
      else s = int'((num * Q16_UNIT) / den);
      c = {mix_channel(lo_col[23:16], hi_col[23:16], s),
           mix_channel(lo_col[15:8],  hi_col[15:8],  s),
           mix_channel(lo_col[7:0],   hi_col[7:0],   s)};
    end
    res.red   = c[23:16];
    res.green = c[15:8];
    res.blue  = c[7:0];
    res.seg   = 4'(walk_pos);
    return 1'b1;
  endfunction

  // item builders
  function automatic shade_item_t scrambled_item(input logic [gfcs_pkg::CMD_W-1:0] cmd);
    shade_item_t it;
    it.cmd         = cmd;
    it.slot        = gfcs_pkg::SLOT_W'($urandom());
    it.slot_offset = gfcs_pkg::OFF_W'($urandom());
    it.slot_color  = gfcs_pkg::COL_W'($urandom());
    it.proj_apex   = gfcs_pkg::PROJ_W'($urandom());
    it.proj_left   = gfcs_pkg::PROJ_W'($urandom());
    it.proj_right  = gfcs_pkg::PROJ_W'($urandom());
    return it;
  endfunction

  function automatic shade_item_t stop_item(input int slot, input int off, input int col);
    shade_item_t it;
    it = scrambled_item(gfcs_pkg::CMD_WRITE);
    it.slot        = gfcs_pkg::SLOT_W'(slot);
    it.slot_offset = gfcs_pkg::OFF_W'(off);
    it.slot_color  = gfcs_pkg::COL_W'(col);
    return it;
  endfunction

  function automatic shade_item_t shade_item(input int a, input int l, input int r);
    shade_item_t it;
    it = scrambled_item(gfcs_pkg::CMD_SHADE);
    it.proj_apex  = gfcs_pkg::PROJ_W'(a);
    it.proj_left  = gfcs_pkg::PROJ_W'(l);
    it.proj_right = gfcs_pkg::PROJ_W'(r);
    return it;
  endfunction

  // three projections whose floored mean is m
  function automatic shade_item_t shade_at(input int m);
    int d1;
    int d2;
    d1 = int'($urandom_range(40000, 0)) - 20000;
    d2 = int'($urandom_range(40000, 0)) - 20000;
    return shade_item(m + d1, m + d2, m - d1 - d2 + int'($urandom_range(2, 0)));
  endfunction

  // One path: optional table reload, usually a start, then shades with mostly rising means.
  task automatic queue_path(output int added);
    int offs [$];
    int means [$];
    int k;
    int n;
    int off;
    int col;
    added = 0;
    if ($urandom_range(2, 0) == 0) begin
      k = $urandom_range(STOP_SLOTS, 1);
      for (int i = 0; i < k; i++) offs.push_back($urandom_range(Q16_UNIT, 0));
      if ($urandom_range(7, 0) != 0) offs.sort();
      for (int i = 0; i < k; i++) begin
        off = ($urandom_range(15, 0) == 0) ? $urandom_range(17'h1FFFF, Q16_UNIT) : offs[i];
        case ($urandom_range(9, 0))
          0:       col = 0;
          1:       col = 24'hFFFFFF;
          default: col = $urandom_range(24'hFFFFFF, 0);
        endcase
        cmds_pending.push_back(stop_item(i, off, col));
        added++;
      end
    end
    if ($urandom_range(5, 0) != 0) begin
      cmds_pending.push_back(scrambled_item(gfcs_pkg::CMD_START));
      added++;
    end
    n = $urandom_range(6, 1);
    for (int i = 0; i < n; i++) means.push_back(int'($urandom_range(82000, 0)) - 8192);
    if ($urandom_range(7, 0) != 0) means.sort();
    foreach (means[i]) begin
      cmds_pending.push_back(shade_at(means[i]));
      added++;
    end
    // occasional noise: ignored command, wild shade or stray stop write
    case ($urandom_range(11, 0))
      0: cmds_pending.push_back(scrambled_item(gfcs_pkg::CMD_NONE));
      1: begin
        cmds_pending.push_back(scrambled_item(gfcs_pkg::CMD_SHADE));
        added++;
      end
      2: begin
        cmds_pending.push_back(scrambled_item(gfcs_pkg::CMD_WRITE));
        added++;
      end
      default: ;
    endcase
  endtask

  task automatic cfg_write(input logic [3:0] v);
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= STOPS_ADDR;
    cfg_pwdata  <= gfcs_pkg::CFG_DATA_W'(v);
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    stops_cfg = v;
  endtask

  task automatic cfg_check(input logic [3:0] v);
    logic [gfcs_pkg::CFG_DATA_W-1:0] rd;
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= STOPS_ADDR;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    rd = cfg_prdata;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    if (rd[3:0] !== v) flag_mismatch($sformatf("stops_in_use read %0h, wrote %0h", rd, v));
  endtask

  // wait for every item to go in and every fill to come out, then let the tail settle
  task automatic drain();
    while (cmds_pending.size() != 0 || fills_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // input driver
  always @(posedge clk) begin
    shade_item_t cur;
    fill_t f;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      gap_left = 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        cur = cmds_pending.pop_front();
        if (fill_for_item(cur, f)) fills_due.push_back(f);
        if (in_gap_pct != 0 && $urandom_range(99, 0) < in_gap_pct)
          gap_left = $urandom_range(10, 1);
      end
      if (gap_left > 0) begin
        gap_left--;
        in_ch.valid <= 1'b0;
      end else if (cmds_pending.size() != 0) begin
        cur = cmds_pending[0];
        in_ch.valid       <= 1'b1;
        in_ch.cmd         <= cur.cmd;
        in_ch.slot        <= cur.slot;
        in_ch.slot_offset <= cur.slot_offset;
        in_ch.slot_color  <= cur.slot_color;
        in_ch.proj_apex   <= cur.proj_apex;
        in_ch.proj_left   <= cur.proj_left;
        in_ch.proj_right  <= cur.proj_right;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // result side back-pressure
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      stall_left = 0;
      hold_left  = 0;
    end else begin
      if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else if (out_stall_pct != 0 && $urandom_range(99, 0) < out_stall_pct) begin
        stall_left = $urandom_range(10, 1) - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    fill_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (fills_due.size() == 0) begin
        flag_mismatch($sformatf("unexpected fill %02h%02h%02h seg %0d", out_ch.fill_red,
                                out_ch.fill_green, out_ch.fill_blue, out_ch.segment_index));
      end else begin
        want = fills_due.pop_front();
        if (out_ch.fill_red !== want.red)
          flag_mismatch($sformatf("fill_red %0h, want %0h", out_ch.fill_red, want.red));
        if (out_ch.fill_green !== want.green)
          flag_mismatch($sformatf("fill_green %0h, want %0h", out_ch.fill_green, want.green));
        if (out_ch.fill_blue !== want.blue)
          flag_mismatch($sformatf("fill_blue %0h, want %0h", out_ch.fill_blue, want.blue));
        if (out_ch.segment_index !== want.seg)
          flag_mismatch($sformatf("segment_index %0d, want %0d", out_ch.segment_index,
                                  want.seg));
      end
    end
  end

  // watchdog: cycles without any item moving on either channel
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    logic [3:0] cfg_plan [PHASES];
    int queued;
    int n;
    rst_n             = 1'b0;
    cfg_psel          = 1'b0;
    cfg_penable       = 1'b0;
    cfg_pwrite        = 1'b0;
    cfg_paddr         = '0;
    cfg_pwdata        = '0;
    in_ch.valid       = 1'b0;
    in_ch.cmd         = gfcs_pkg::CMD_NONE;
    in_ch.slot        = '0;
    in_ch.slot_offset = '0;
    in_ch.slot_color  = '0;
    in_ch.proj_apex   = '0;
    in_ch.proj_left   = '0;
    in_ch.proj_right  = '0;
    out_ch.ready      = 1'b0;
    cfg_plan = '{4'd0, 4'd15, 4'd1, 4'd9, 4'd8, 4'd2, 4'd5, 4'd7};
    cfg_plan[6] = 4'($urandom_range(STOP_SLOTS, 2));

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    cfg_check(gfcs_pkg::STOPS_RESET);

    // fill the whole table first: equal and descending offsets, an over-range offset
    in_gap_pct    = 20;
    out_stall_pct = 20;
    cmds_pending.push_back(stop_item(0, 4096, 24'hFF0000));
    cmds_pending.push_back(stop_item(1, 16384, 24'h00FF00));
    cmds_pending.push_back(stop_item(2, 16384, 24'h0000FF));
    cmds_pending.push_back(stop_item(3, 12000, 24'hFFFFFF));
    cmds_pending.push_back(stop_item(4, 32768, 24'h000000));
    cmds_pending.push_back(stop_item(5, 49152, 24'h123456));
    cmds_pending.push_back(stop_item(6, 65536, 24'hABCDEF));
    cmds_pending.push_back(stop_item(7, 17'h1FFFF, 24'h80FF01));
    cmds_pending.push_back(scrambled_item(gfcs_pkg::CMD_NONE));
    cmds_pending.push_back(scrambled_item(gfcs_pkg::CMD_START));
    // two stops: before first, blended, past end
    cmds_pending.push_back(shade_item(-524288, -524288, -524288));
    cmds_pending.push_back(shade_at(10000));
    cmds_pending.push_back(shade_item(524287, 524287, 524287));
    drain();

    cfg_write(4'd8);
    cfg_check(4'd8);
    cmds_pending.push_back(scrambled_item(gfcs_pkg::CMD_START));
    cmds_pending.push_back(shade_item(-1, 0, 0));
    cmds_pending.push_back(shade_at(16384));
    cmds_pending.push_back(shade_at(20000));
    // mean falls back below the lower stop: walk stays, blend clamps
    cmds_pending.push_back(shade_at(10000));
    cmds_pending.push_back(shade_item(524287, 524287, 524287));
    drain();

    // count shrunk under a walk that is past the end
    cfg_write(4'd3);
    cfg_check(4'd3);
    cmds_pending.push_back(shade_at(0));

    for (int p = 0; p < PHASES; p++) begin
      drain();
      cfg_write(cfg_plan[p]);
      cfg_check(cfg_plan[p]);
      case (p)
        1: begin
          // sender keeps offering while the result side is held off
          in_gap_pct    = 0;
          out_stall_pct = 10;
          hold_req      = 1'b1;
        end
        3, 7: begin
          in_gap_pct    = 0;
          out_stall_pct = 0;
        end
        default: begin
          in_gap_pct    = (p % 2 == 0) ? 30 : 10;
          out_stall_pct = (p % 2 == 0) ? 30 : 50;
        end
      endcase
      queued = 0;
      while (queued < PHASE_ITEMS) begin
        queue_path(n);
        queued += n;
      end
    end
    drain();

    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

/* files.f */
hdl/gfcs_pkg.sv
hdl/gfcs_in_if.sv
hdl/gfcs_out_if.sv
hdl/gfcs_ram.sv
hdl/gfcs_front.sv
hdl/gfcs_queue.sv
hdl/gfcs_back.sv
hdl/gradient_fan_color_shader_core.sv
dv/tb_gradient_fan_color_shader_core.sv
